// ----- src/ppst_pkg.sv -----
package ppst_pkg;

	// path store geometry
	localparam int PATH_DEPTH = 4096;
	localparam int IDX_W      = $clog2(PATH_DEPTH);
	localparam int N_W        = $clog2(PATH_DEPTH + 1);
	localparam int COORD_BITS = 24;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int SUM_W      = SQ_W + 1;
	localparam int PT_W       = 2 * COORD_BITS;

	// front queue
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// cordic widths
	localparam int CW           = 50;
	localparam int ZW           = 34;
	localparam int ANG_W        = 32;
	localparam int SIN_W        = 33;
	localparam int CORDIC_STEPS = 24;
	localparam int STEP_W       = 5;
	localparam int NORM_BIT     = 45;
	localparam logic signed [CW-1:0] K_INIT = CW'(652032874);
	localparam logic [ANG_W-1:0] ANG_HALF = 32'h8000_0000;
	localparam logic [ANG_W-1:0] ANG_QTR  = 32'h4000_0000;
	localparam logic [ANG_W-1:0] ANG_3QTR = 32'hC000_0000;

	// heading conversion
	localparam int H_W     = 16;
	localparam int P_W     = 18;
	localparam int PABS_W  = 17;
	localparam int H_LO    = -11520;
	localparam int H_HI    = 23040;
	localparam int P_OFS_A = 11520;
	localparam int P_OFS_B = -34560;

	// scaling by 2^22 / 45: |p| * DIV_Q + (|p| * DIV_R + DIV_RND) / 45
	localparam int DIV_Q   = 93206;
	localparam int DIV_R   = 34;
	localparam int DIV_RND = 22;
	// reciprocal of 45, exact for numerators below 2^23
	localparam int DIV_M   = 11930465;
	localparam int DIV_MSH = 29;
	localparam int DQ_W    = 34;
	localparam int DM_W    = 23;
	localparam int DMP_W   = 47;

	// output scaling
	localparam int RAD_SCALE = 411775;
	localparam int STEER_W   = 16;
	localparam int STEER_MAX = 25736;
	localparam int OUT_IDX_W = 12;

	// configuration registers
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WHEELBASE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATH_LEN  = 2'd2;
	localparam int LA_RESET = 512;
	localparam int WB_RESET = 691;
	localparam int PL_RESET = 4096;

	// request kinds
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_POSE = 1'b1;

	typedef struct packed {
		logic                         req_type;
		logic [11:0]                  point_index;
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic signed [H_W-1:0]        heading;
	} req_t;

	typedef struct packed {
		logic signed [STEER_W-1:0] steering;
		logic [OUT_IDX_W-1:0]      nearest_index;
		logic                      waypoint_found;
	} res_t;

	typedef struct packed {
		logic [15:0] lookahead_dist;
		logic [11:0] wheelbase;
		logic [12:0] path_length;
	} cfg_t;

	typedef struct packed {
		logic valid;
		req_t item;
	} fifo_out_t;

	// arctangent of 2^-i in binary angle units
	function automatic logic [29:0] ang_tab(input logic [STEP_W-1:0] i);
		logic [29:0] v;
		unique case (i)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- src/ppst_front.sv -----
module ppst_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ppst_pkg::req_t      request,
	input  logic                pop,
	output ppst_pkg::fifo_out_t q
);
	import ppst_pkg::*;

	req_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  push;
	logic                  pull;

	assign busy = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign push = start && !busy;
	assign pull = pop && (cnt_q != '0);
	assign q.valid = (cnt_q != '0);
	assign q.item  = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pull) begin
				rd_q <= (rd_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pull) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pull && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// item storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= request;
		end
	end

endmodule

// ----- src/ppst_cordic.sv -----
module ppst_cordic (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 go,
	input  logic                                 vec_mode,
	input  logic signed [ppst_pkg::CW-1:0]       x0,
	input  logic signed [ppst_pkg::CW-1:0]       y0,
	input  logic [ppst_pkg::ANG_W-1:0]           z0,
	output logic                                 fin,
	output logic [ppst_pkg::ANG_W-1:0]           angle,
	output logic signed [ppst_pkg::SIN_W-1:0]    sine
);
	import ppst_pkg::*;

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_NORM = 2'd1;
	localparam logic [1:0] C_ITER = 2'd2;

	localparam logic signed [CW-1:0] NORM_LIM = CW'(1) <<< NORM_BIT;
	localparam logic signed [ZW-1:0] Z_QTR    = ZW'(1) <<< 30;
	localparam logic signed [ZW-1:0] Z_HALF   = ZW'(1) <<< 31;

	logic [1:0]               cst_q;
	logic signed [CW-1:0]     x_q;
	logic signed [CW-1:0]     y_q;
	logic signed [ZW-1:0]     z_q;
	logic [STEP_W-1:0]        i_q;
	logic                     vec_q;
	logic                     neg_q;
	logic                     base_q;
	logic                     fin_q;
	logic [ANG_W-1:0]         angle_q;
	logic signed [SIN_W-1:0]  sine_q;

	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [ZW-1:0] tab;
	logic                 up;
	logic signed [CW-1:0] x_nx;
	logic signed [CW-1:0] y_nx;
	logic signed [ZW-1:0] z_nx;
	logic signed [CW-1:0] ax;
	logic signed [CW-1:0] ay;
	logic signed [CW-1:0] mx;
	logic signed [ZW-1:0] zs;

	assign fin   = fin_q;
	assign angle = angle_q;
	assign sine  = sine_q;

	// one micro-rotation
	always_comb begin
		xs  = x_q >>> i_q;
		ys  = y_q >>> i_q;
		tab = ZW'(ang_tab(i_q));
		up  = vec_q ? (y_q > 0) : (z_q < 0);
		if (up) begin
			x_nx = x_q + ys;
			y_nx = y_q - xs;
			z_nx = z_q + tab;
		end else begin
			x_nx = x_q - ys;
			y_nx = y_q + xs;
			z_nx = z_q - tab;
		end
		ax = (x_q < 0) ? -x_q : x_q;
		ay = (y_q < 0) ? -y_q : y_q;
		mx = (ax > ay) ? ax : ay;
		zs = ZW'($signed(z0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q <= C_IDLE;
			fin_q <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			unique case (cst_q)
				C_IDLE: begin
					if (go && vec_mode) begin
						if (y0 == 0 || x0 == 0) begin
							fin_q <= 1'b1;
						end else begin
							cst_q <= C_NORM;
						end
					end else if (go) begin
						cst_q <= C_ITER;
					end
				end
				C_NORM: begin
					if (mx >= NORM_LIM) begin
						cst_q <= C_ITER;
					end
				end
				C_ITER: begin
					if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
						cst_q <= C_IDLE;
						fin_q <= 1'b1;
					end
				end
				default: cst_q <= C_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (cst_q)
			C_IDLE: begin
				i_q   <= '0;
				vec_q <= vec_mode;
				if (go && vec_mode) begin
					if (y0 == 0) begin
						angle_q <= (x0 < 0) ? ANG_HALF : '0;
					end else if (x0 == 0) begin
						angle_q <= (y0 > 0) ? ANG_QTR : ANG_3QTR;
					end
					x_q    <= (x0 < 0) ? -x0 : x0;
					y_q    <= (x0 < 0) ? -y0 : y0;
					base_q <= (x0 < 0);
					z_q    <= '0;
				end else if (go) begin
					// fold the angle into the right half plane
					if (zs > Z_QTR) begin
						z_q   <= zs - Z_HALF;
						neg_q <= 1'b1;
					end else if (zs < -Z_QTR) begin
						z_q   <= zs + Z_HALF;
						neg_q <= 1'b1;
					end else begin
						z_q   <= zs;
						neg_q <= 1'b0;
					end
					x_q    <= K_INIT;
					y_q    <= '0;
					base_q <= 1'b0;
				end
			end
			C_NORM: begin
				if (mx < NORM_LIM) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			C_ITER: begin
				x_q <= x_nx;
				y_q <= y_nx;
				z_q <= z_nx;
				i_q <= i_q + 1'b1;
				if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
					angle_q <= (base_q ? ANG_HALF : '0) + z_nx[ANG_W-1:0];
					sine_q  <= neg_q ? -SIN_W'(y_nx) : SIN_W'(y_nx);
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- src/ppst_back.sv -----
module ppst_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ppst_pkg::fifo_out_t q,
	output logic                pop,
	input  ppst_pkg::cfg_t      cfg,
	output logic                done,
	output ppst_pkg::res_t      result
);
	import ppst_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_W1   = 4'd1;
	localparam logic [3:0] ST_W2   = 4'd2;
	localparam logic [3:0] ST_DIV  = 4'd3;
	localparam logic [3:0] ST_A1   = 4'd4;
	localparam logic [3:0] ST_A1W  = 4'd5;
	localparam logic [3:0] ST_SIN  = 4'd6;
	localparam logic [3:0] ST_SINW = 4'd7;
	localparam logic [3:0] ST_MUL  = 4'd8;
	localparam logic [3:0] ST_A2   = 4'd9;
	localparam logic [3:0] ST_A2W  = 4'd10;
	localparam logic [3:0] ST_FIN1 = 4'd11;
	localparam logic [3:0] ST_FIN2 = 4'd12;
	localparam logic [3:0] ST_DIV2 = 4'd13;

	localparam int PROD_W = SIN_W + 20;

	logic [3:0] state_q;

	// path store
	logic [PT_W-1:0] mem [PATH_DEPTH];
	logic [PT_W-1:0] pt_s1;

	// pose and walk control
	logic signed [COORD_BITS-1:0] px_q;
	logic signed [COORD_BITS-1:0] py_q;
	logic [N_W-1:0]               n_q;
	logic [N_W-1:0]               cnt_q;
	logic [IDX_W-1:0]             near_q;
	logic [SUM_W-1:0]             best_q;
	logic [SUM_W-1:0]             ld2_q;
	logic                         first_q;
	logic                         found_q;
	logic signed [COORD_BITS-1:0] wp_x_q;
	logic signed [COORD_BITS-1:0] wp_y_q;

	// distance pipeline
	logic                 v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0]     idx_s1, idx_s2, idx_s3, idx_s4;
	logic [PT_W-1:0]      pt_s2, pt_s3, pt_s4;
	logic [DIFF_W-1:0]    dx_s2, dy_s2;
	logic [SQ_W-1:0]      sqx_s3, sqy_s3;
	logic [SUM_W-1:0]     d_s4;

	// heading scaling
	logic [PABS_W-1:0] pabs_q;
	logic [DQ_W-1:0]   dqb_q;
	logic [DM_W-1:0]   dm_q;
	logic [ANG_W-1:0]  dq_q;
	logic              pneg_q;

	// angle chain
	logic [ANG_W-1:0]        alpha_q;
	logic signed [SIN_W-1:0] sin_q;
	logic signed [CW-1:0]    num_q;
	logic [ANG_W-1:0]        b_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                    done_q;
	res_t                    res_q;

	// cordic hookup
	logic                 c_go;
	logic                 c_vec;
	logic signed [CW-1:0] c_x;
	logic signed [CW-1:0] c_y;
	logic                 c_fin;
	logic [ANG_W-1:0]     c_angle;
	logic signed [SIN_W-1:0] c_sine;

	logic                   take;
	logic                   is_load;
	logic                   issue;
	logic                   drained;
	logic [N_W-1:0]         n_cl;
	logic signed [P_W-1:0]  h_ext;
	logic signed [P_W-1:0]  p_val;
	logic [PABS_W-1:0]      p_abs;
	logic [DMP_W-1:0]       dm_prod;
	logic [ANG_W-1:0]       psi;
	logic signed [DIFF_W-1:0] sx, sy;
	logic signed [PROD_W+1:0] rnd;
	logic signed [PROD_W-33:0] steer_w;
	logic signed [STEER_W-1:0] steer_sat;
	logic [COORD_BITS-1:0]  ptx_s1, pty_s1;

	assign take    = (state_q == ST_IDLE) && q.valid;
	assign pop     = take;
	assign is_load = (q.item.req_type == REQ_LOAD);
	assign done    = done_q;
	assign result  = res_q;

	// front-end decode and walk bookkeeping
	always_comb begin
		n_cl = (cfg.path_length == '0) ? N_W'(1)
			: (int'(cfg.path_length) > PATH_DEPTH) ? N_W'(PATH_DEPTH)
			: N_W'(cfg.path_length);
		issue = ((state_q == ST_W1) && (cnt_q < n_q))
			|| ((state_q == ST_W2) && (cnt_q < n_q) && !found_q);
		drained = !issue && !v_s1 && !v_s2 && !v_s3 && !v_s4;
		h_ext = P_W'(q.item.heading);
		if (h_ext > P_W'(H_LO) && h_ext < P_W'(H_HI)) begin
			p_val = P_W'(P_OFS_A) - h_ext;
		end else begin
			p_val = P_W'(P_OFS_B) - h_ext;
		end
		p_abs   = (p_val < 0) ? PABS_W'(-p_val) : PABS_W'(p_val);
		dm_prod = DMP_W'(dm_q) * DMP_W'(DIV_M);
		psi     = pneg_q ? ANG_W'(0) - dq_q : dq_q;
		ptx_s1 = pt_s1[PT_W-1:COORD_BITS];
		pty_s1 = pt_s1[COORD_BITS-1:0];
		sx = DIFF_W'($signed(ptx_s1)) - DIFF_W'(px_q);
		sy = DIFF_W'($signed(pty_s1)) - DIFF_W'(py_q);
		rnd     = (PROD_W + 2)'(prod_q) + ((PROD_W + 2)'(1) <<< 33);
		steer_w = (PROD_W - 32)'(rnd >>> 34);
		if (steer_w > (PROD_W - 32)'(STEER_MAX)) begin
			steer_sat = STEER_W'(STEER_MAX);
		end else if (steer_w < -(PROD_W - 32)'(STEER_MAX)) begin
			steer_sat = -STEER_W'(STEER_MAX);
		end else begin
			steer_sat = STEER_W'(steer_w);
		end
	end

	// cordic arguments per step
	always_comb begin
		c_go  = (state_q == ST_A1) || (state_q == ST_SIN) || (state_q == ST_A2);
		c_vec = (state_q != ST_SIN);
		if (state_q == ST_A2) begin
			c_x = CW'({cfg.lookahead_dist, 30'b0});
			c_y = num_q;
		end else begin
			c_x = CW'(DIFF_W'(wp_y_q) - DIFF_W'(py_q));
			c_y = CW'(DIFF_W'(wp_x_q) - DIFF_W'(px_q));
		end
	end

	ppst_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (c_go),
		.vec_mode (c_vec),
		.x0       (c_x),
		.y0       (c_y),
		.z0       (alpha_q),
		.fin      (c_fin),
		.angle    (c_angle),
		.sine     (c_sine)
	);

	// store write and registered read
	always_ff @(posedge clk) begin
		if (take && is_load && int'(q.item.point_index) < PATH_DEPTH) begin
			mem[IDX_W'(q.item.point_index)] <= {q.item.pos_x, q.item.pos_y};
		end
		if (issue) begin
			pt_s1 <= mem[cnt_q[IDX_W-1:0]];
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			found_q <= 1'b0;
			first_q <= 1'b0;
			wp_x_q  <= '0;
			wp_y_q  <= '0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= issue;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			// compare stage
			if (v_s4 && state_q == ST_W1) begin
				first_q <= 1'b0;
			end
			if (v_s4 && state_q == ST_W2 && !found_q && d_s4 > ld2_q) begin
				found_q <= 1'b1;
				wp_x_q  <= pt_s4[PT_W-1:COORD_BITS];
				wp_y_q  <= pt_s4[COORD_BITS-1:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take && !is_load) begin
						state_q <= ST_W1;
						cnt_q   <= '0;
						first_q <= 1'b1;
						found_q <= 1'b0;
					end
				end
				ST_W1: begin
					if (drained) begin
						state_q <= ST_W2;
						cnt_q   <= N_W'(near_q);
					end
				end
				ST_W2: begin
					if (drained) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV:  state_q <= ST_DIV2;
				ST_DIV2: state_q <= ST_A1;
				ST_A1:   state_q <= ST_A1W;
				ST_A1W:  if (c_fin) state_q <= ST_SIN;
				ST_SIN:  state_q <= ST_SINW;
				ST_SINW: if (c_fin) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_A2;
				ST_A2:   state_q <= ST_A2W;
				ST_A2W:  if (c_fin) state_q <= ST_FIN1;
				ST_FIN1: state_q <= ST_FIN2;
				ST_FIN2: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IDX_W-1:0];
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		pt_s2  <= pt_s1;
		pt_s3  <= pt_s2;
		pt_s4  <= pt_s3;
		dx_s2  <= (sx < 0) ? DIFF_W'(-sx) : DIFF_W'(sx);
		dy_s2  <= (sy < 0) ? DIFF_W'(-sy) : DIFF_W'(sy);
		sqx_s3 <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
		sqy_s3 <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
		d_s4   <= SUM_W'(sqx_s3) + SUM_W'(sqy_s3);
		if (take && !is_load) begin
			px_q   <= q.item.pos_x;
			py_q   <= q.item.pos_y;
			n_q    <= n_cl;
			near_q <= '0;
			ld2_q  <= SUM_W'(cfg.lookahead_dist) * SUM_W'(cfg.lookahead_dist);
			pabs_q <= p_abs;
			pneg_q <= (p_val < 0);
		end
		// nearest point, first of equal minima
		if (v_s4 && state_q == ST_W1 && (first_q || d_s4 < best_q)) begin
			best_q <= d_s4;
			near_q <= idx_s4;
		end
		// heading scaling, integer part and remainder term
		if (state_q == ST_DIV) begin
			dqb_q <= DQ_W'(pabs_q) * DQ_W'(DIV_Q);
			dm_q  <= DM_W'(pabs_q) * DM_W'(DIV_R) + DM_W'(DIV_RND);
		end
		// remainder term divided by reciprocal multiplication
		if (state_q == ST_DIV2) begin
			dq_q <= dqb_q[ANG_W-1:0] + ANG_W'(dm_prod >> DIV_MSH);
		end
		if (state_q == ST_A1W && c_fin) begin
			alpha_q <= c_angle - psi;
		end
		if (state_q == ST_SINW && c_fin) begin
			sin_q <= c_sine;
		end
		if (state_q == ST_MUL) begin
			num_q <= $signed(CW'({1'b0, cfg.wheelbase, 1'b0})) * CW'(sin_q);
		end
		if (state_q == ST_A2W && c_fin) begin
			b_q <= c_angle;
		end
		if (state_q == ST_FIN1) begin
			prod_q <= PROD_W'(-(SIN_W'($signed(b_q)))) * PROD_W'(RAD_SCALE);
		end
		if (state_q == ST_FIN2) begin
			res_q.steering       <= steer_sat;
			res_q.nearest_index  <= OUT_IDX_W'(near_q);
			res_q.waypoint_found <= found_q;
		end
	end

endmodule

// ----- src/pure_pursuit_steering.sv -----
// pure pursuit steering block
//
// request channel: an item is taken at a clock edge with start high and busy
// low. a load item writes one path point at point_index; a pose item starts
// a steering computation. two items may wait in the input queue while the
// back end works, busy is high only while that queue is full.
// result channel: done is high for one cycle with result valid in the same
// cycle; one result per pose item, none per load item, in request order.
// the receiver cannot stall, so nothing is ever held back on this side.
// config port: cfg_we writes cfg_data into register cfg_index
// (0 lookahead_dist, 1 wheelbase, 2 path_length); write only while idle.
// back end: while idle it takes a load item in the cycle after it is queued
// and then one per cycle. a pose item makes two passes over the n path points
// through the single store read port, then heading scaling in ST_DIV and
// ST_DIV2, three cordic runs and the output steps; no item is taken until
// done. the store read port sets the walk rate.
// reset: clears queue, sequencer, waypoint and config registers to defaults;
// the path store holds no reset value and must be loaded before use.
module pure_pursuit_steering (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  ppst_pkg::req_t                     request,
	output logic                               done,
	output ppst_pkg::res_t                     result,
	input  logic                               cfg_we,
	input  logic [ppst_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppst_pkg::CFG_W-1:0]         cfg_data
);
	import ppst_pkg::*;

	cfg_t      cfg_q;
	fifo_out_t q;
	logic      pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lookahead_dist <= 16'(LA_RESET);
			cfg_q.wheelbase      <= 12'(WB_RESET);
			cfg_q.path_length    <= 13'(PL_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOOKAHEAD: cfg_q.lookahead_dist <= cfg_data;
				CFG_WHEELBASE: cfg_q.wheelbase      <= cfg_data[11:0];
				CFG_PATH_LEN:  cfg_q.path_length    <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	ppst_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.pop     (pop),
		.q       (q)
	);

	ppst_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q      (q),
		.pop    (pop),
		.cfg    (cfg_q),
		.done   (done),
		.result (result)
	);

endmodule

// ----- src/ppst_checker.sv -----
module ppst_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input ppst_pkg::res_t result
);
	import ppst_pkg::*;

	// results never come back to back
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	// steering stays inside the saturation limits
	a_steer_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.steering <= 16'sd25736 && result.steering >= -16'sd25736))
		else $error("steering outside saturation range");

	// the queue only fills up after an item was taken
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an accepted item");

endmodule

bind pure_pursuit_steering ppst_checker u_ppst_checker (.*);
